// ===== hdl/tcw_pkg.sv =====
// package: geometry, codes and payload types of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;

   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int ADDR_W  = $clog2(CELL_COUNT);
   localparam int SWEEP_W = $clog2(CELL_COUNT + 1);
   localparam int POS_W   = 11;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 1'b1;
   localparam logic [3:0] FOREGROUND_RESET = 4'd7;
   localparam logic [3:0] BACKGROUND_RESET = 4'd0;

   // action codes
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // character codes
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_PRINT_LAST = 8'h7F;
   localparam logic [7:0] CHAR_QUESTION   = 8'h3F;

   typedef struct packed {
      logic [3:0] background;
      logic [3:0] foreground;
      logic [7:0] char_code;
   } tcw_cell_type;

   localparam tcw_cell_type BLANK_CELL = '{background: 4'h0, foreground: 4'h7,
                                           char_code: CHAR_SPACE};

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      tcw_cell_type      wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } tcw_ram_req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  char_code;
      logic [10:0] cell_address;
   } tcw_req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [7:0]  cell_char;
      logic [3:0]  cell_foreground;
      logic [3:0]  cell_background;
      logic        scrolled;
   } tcw_rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RMW,
      ST_READ,
      ST_SWEEP
   } tcw_state_type;

endpackage

// ===== hdl/text_console_writer.sv =====
// top level: character-cell screen writer with cursor, scroll and clear
`timescale 1ns / 1ps

// channel   ports                          beat
// -------   -----------------------------  ---------------------------------
// request   start, busy, req_payload       start high while busy low
// result    rsp_valid, rsp_payload         rsp_valid high, one cycle, no stall
// config    csr_we, csr_index, csr_wdata   csr_we high, taken at once
//
// printable put or newline that does not scroll, unused action: result in the cycle after the beat
// unprintable put and cell read: the registered store read comes first
// clear: a walk over the whole store; a put that scrolls also walks the store
//   once, one cell a cycle, reading a row below and writing it in the next cycle
// reset starts a clearing pass over the store, busy meanwhile
// busy follows the state register; after a request it falls in the cycle the result appears

module text_console_writer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  tcw_pkg::tcw_req_type                  req_payload,
   output logic                                  rsp_valid,
   output tcw_pkg::tcw_rsp_type                  rsp_payload,
   input  logic                                  csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   tcw_pkg::tcw_state_type state_ff, state_in;

   logic [tcw_pkg::SWEEP_W-1:0] sweep_ff, sweep_in;
   logic [tcw_pkg::SWEEP_W-1:0] sweep_w;
   logic                        sweep_scroll_ff, sweep_scroll_in;
   logic                        sweep_done;

   logic [tcw_pkg::COL_W-1:0]   col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [tcw_pkg::ADDR_W-1:0]  pos;
   logic [tcw_pkg::ADDR_W-1:0]  pos_next;

   logic [3:0]                  fg_ff, bg_ff;
   logic                        rd_range_ff, rd_range_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   tcw_pkg::tcw_rsp_type        rsp_ff, rsp_in;

   tcw_pkg::tcw_ram_req_type    ram_req;
   tcw_pkg::tcw_cell_type       ram_rdata;

   logic                        accept;
   logic                        is_newline;
   logic                        is_printable;
   logic                        read_in_range;

   // cursor advance
   logic                        adv_newline;
   logic                        wrap;
   logic                        at_last_row;
   logic [tcw_pkg::COL_W-1:0]   adv_col;
   logic [tcw_pkg::ROW_W-1:0]   adv_row;
   logic                        adv_scroll;

   tcw_screen_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rdata)
   );

   assign accept        = start && (state_ff == tcw_pkg::ST_IDLE);
   assign busy          = (state_ff != tcw_pkg::ST_IDLE);
   assign is_newline    = (req_payload.char_code == tcw_pkg::CHAR_NEWLINE);
   assign is_printable  = (req_payload.char_code >= tcw_pkg::CHAR_SPACE) &&
                          (req_payload.char_code <= tcw_pkg::CHAR_PRINT_LAST);
   assign read_in_range = (32'(req_payload.cell_address) < tcw_pkg::CELL_COUNT);

   // linear cursor address, now and after this cycle
   assign pos      = tcw_pkg::ADDR_W'(row_ff * tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(col_ff);
   assign pos_next = tcw_pkg::ADDR_W'(row_in * tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(col_in);

   // a newline or the last column wraps; wrapping on the last row scrolls,
   // and the cursor then stays on the last row
   assign adv_newline = (state_ff == tcw_pkg::ST_IDLE) && is_newline;
   assign wrap        = adv_newline || (col_ff == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
   assign at_last_row = (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
   assign adv_col     = wrap ? '0 : col_ff + 1'b1;
   assign adv_row     = (wrap && !at_last_row) ? row_ff + 1'b1 : row_ff;
   assign adv_scroll  = wrap && at_last_row;

   // sweep: step k writes cell k - 1; a scroll also reads cell k + COLUMNS
   assign sweep_w    = sweep_ff - 1'b1;
   assign sweep_done = (sweep_ff == tcw_pkg::SWEEP_W'(tcw_pkg::CELL_COUNT));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (sweep_done) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_payload.action)
                  tcw_pkg::ACT_PUT: begin
                     if (is_newline || is_printable) begin
                        state_in = adv_scroll ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_IDLE;
                     end else begin
                        state_in = tcw_pkg::ST_RMW;
                     end
                  end
                  tcw_pkg::ACT_CLEAR: state_in = tcw_pkg::ST_SWEEP;
                  tcw_pkg::ACT_READ:  state_in = tcw_pkg::ST_READ;
                  default:            state_in = tcw_pkg::ST_IDLE;
               endcase
            end
         end
         tcw_pkg::ST_RMW:   state_in = adv_scroll ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_IDLE;
         tcw_pkg::ST_READ:  state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_SWEEP: begin
            if (sweep_done) state_in = tcw_pkg::ST_IDLE;
         end
         default:           state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // datapath and store access
   always_comb begin
      col_in          = col_ff;
      row_in          = row_ff;
      sweep_in        = sweep_ff;
      sweep_scroll_in = sweep_scroll_ff;
      rd_range_in     = rd_range_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = '0;

      ram_req         = '0;
      ram_req.rd_addr = pos;
      ram_req.wr_addr = pos;

      unique case (state_ff) inside
         tcw_pkg::ST_INIT, tcw_pkg::ST_SWEEP: begin
            if (!sweep_done) begin
               sweep_in = sweep_ff + 1'b1;
            end
            if (sweep_scroll_ff && (sweep_ff < tcw_pkg::SWEEP_W'(tcw_pkg::MOVE_COUNT))) begin
               ram_req.rd_addr = tcw_pkg::ADDR_W'(sweep_ff) +
                                 tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
            end
            if (sweep_ff != '0) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = tcw_pkg::ADDR_W'(sweep_w);
               // moved rows take the registered read data, the last row blanks
               if (sweep_scroll_ff && (sweep_w < tcw_pkg::SWEEP_W'(tcw_pkg::MOVE_COUNT))) begin
                  ram_req.wr_data = ram_rdata;
               end else begin
                  ram_req.wr_data = tcw_pkg::BLANK_CELL;
               end
            end
            if (sweep_done && (state_ff == tcw_pkg::ST_SWEEP)) begin
               rsp_valid_in    = 1'b1;
               rsp_in.scrolled = sweep_scroll_ff;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               sweep_in        = '0;
               sweep_scroll_in = 1'b0;
               case (req_payload.action)
                  tcw_pkg::ACT_PUT: begin
                     if (is_newline || is_printable) begin
                        if (is_printable) begin
                           ram_req.wr_en   = 1'b1;
                           ram_req.wr_data = '{background: bg_ff, foreground: fg_ff,
                                               char_code: req_payload.char_code};
                        end
                        col_in          = adv_col;
                        row_in          = adv_row;
                        sweep_scroll_in = adv_scroll;
                        rsp_valid_in    = !adv_scroll;
                     end
                     // unprintable bytes keep the cell colors: read first
                  end
                  tcw_pkg::ACT_CLEAR: begin
                     col_in = '0;
                     row_in = '0;
                  end
                  tcw_pkg::ACT_READ: begin
                     ram_req.rd_addr = tcw_pkg::ADDR_W'(req_payload.cell_address);
                     rd_range_in     = read_in_range;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         tcw_pkg::ST_RMW: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_data = '{background: ram_rdata.background,
                                foreground: ram_rdata.foreground,
                                char_code:  tcw_pkg::CHAR_QUESTION};
            col_in          = adv_col;
            row_in          = adv_row;
            sweep_in        = '0;
            sweep_scroll_in = adv_scroll;
            rsp_valid_in    = !adv_scroll;
         end
         tcw_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            if (rd_range_ff) begin
               rsp_in.cell_char       = ram_rdata.char_code;
               rsp_in.cell_foreground = ram_rdata.foreground;
               rsp_in.cell_background = ram_rdata.background;
            end
         end
         default: begin
         end
      endcase

      rsp_in.cursor_position = tcw_pkg::POS_W'(pos_next);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tcw_pkg::ST_INIT;
         sweep_ff        <= '0;
         sweep_scroll_ff <= 1'b0;
         col_ff          <= '0;
         row_ff          <= '0;
         rd_range_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sweep_ff        <= sweep_in;
         sweep_scroll_ff <= sweep_scroll_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         rd_range_ff     <= rd_range_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= tcw_pkg::FOREGROUND_RESET;
         bg_ff <= tcw_pkg::BACKGROUND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tcw_pkg::CSR_FOREGROUND: fg_ff <= csr_wdata;
            tcw_pkg::CSR_BACKGROUND: bg_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/tcw_screen_ram.sv =====
// screen cell store: one write port, one registered read port
`timescale 1ns / 1ps

module tcw_screen_ram (
   input  logic                     clock,
   input  tcw_pkg::tcw_ram_req_type ram_req,
   output tcw_pkg::tcw_cell_type    rd_data
);

   tcw_pkg::tcw_cell_type mem [tcw_pkg::CELL_COUNT];
   tcw_pkg::tcw_cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/tb_text_console_writer.sv =====
// testbench: self-checking scoreboard for the text console writer
`timescale 1ns / 1ps

module tb_text_console_writer;

   // action code with no function, must leave the screen alone
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // worst case is a store walk per beat plus the longest sender gap, for
   // roughly 500 beats, then taken about five times over
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int MAX_GAP     = 40;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   tcw_pkg::tcw_req_type req_payload;
   logic                 rsp_valid;
   tcw_pkg::tcw_rsp_type rsp_payload;
   logic                 csr_we;
   logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata;

   text_console_writer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // shadow copy of the screen, cursor and color registers
   tcw_pkg::tcw_cell_type shadow_screen [tcw_pkg::CELL_COUNT];
   int                    shadow_col;
   int                    shadow_row;
   logic [3:0]            shadow_fg;
   logic [3:0]            shadow_bg;

   // results owed by the block, oldest first
   tcw_pkg::tcw_rsp_type  results_due [$];

   int fail_count;
   int cycle_count;
   int sender_idle_pct;
   int put_count;
   int clear_count;
   int read_count;
   int other_count;
   int scroll_count;

   // 20 ns clock
   always #10 clock = ~clock;

   // screen behavior: apply one beat to the shadow state, return the result
   function automatic tcw_pkg::tcw_rsp_type console_step(input tcw_pkg::tcw_req_type beat);
      tcw_pkg::tcw_rsp_type  outcome;
      tcw_pkg::tcw_cell_type read_cell;
      int                    pos;
      int                    i;
      outcome = '0;
      case (beat.action)
         tcw_pkg::ACT_PUT: begin
            pos = shadow_row * tcw_pkg::COLUMNS + shadow_col;
            if (beat.char_code == tcw_pkg::CHAR_NEWLINE) begin
               shadow_col = 0;
               shadow_row++;
            end else if (beat.char_code >= tcw_pkg::CHAR_SPACE &&
                         beat.char_code <= tcw_pkg::CHAR_PRINT_LAST) begin
               shadow_screen[pos] = '{background: shadow_bg, foreground: shadow_fg,
                                      char_code: beat.char_code};
               shadow_col++;
            end else begin
               // unprintable byte: char becomes '?', colors kept
               shadow_screen[pos].char_code = tcw_pkg::CHAR_QUESTION;
               shadow_col++;
            end
            // row end wrap
            if (shadow_col >= tcw_pkg::COLUMNS) begin
               shadow_col = 0;
               shadow_row++;
            end
            // screen end: move all rows up, blank the bottom one
            if (shadow_row >= tcw_pkg::ROWS) begin
               for (i = 0; i < tcw_pkg::MOVE_COUNT; i++)
                  shadow_screen[i] = shadow_screen[i + tcw_pkg::COLUMNS];
               for (i = tcw_pkg::MOVE_COUNT; i < tcw_pkg::CELL_COUNT; i++)
                  shadow_screen[i] = tcw_pkg::BLANK_CELL;
               shadow_row = tcw_pkg::ROWS - 1;
               outcome.scrolled = 1'b1;
            end
         end
         tcw_pkg::ACT_CLEAR: begin
            for (i = 0; i < tcw_pkg::CELL_COUNT; i++)
               shadow_screen[i] = tcw_pkg::BLANK_CELL;
            shadow_col = 0;
            shadow_row = 0;
         end
         tcw_pkg::ACT_READ: begin
            // addresses past the screen read back as all zero
            if (beat.cell_address < tcw_pkg::CELL_COUNT) begin
               read_cell = shadow_screen[beat.cell_address];
               outcome.cell_char       = read_cell.char_code;
               outcome.cell_foreground = read_cell.foreground;
               outcome.cell_background = read_cell.background;
            end
         end
         default: ;
      endcase
      outcome.cursor_position = tcw_pkg::POS_W'(shadow_row * tcw_pkg::COLUMNS + shadow_col);
      return outcome;
   endfunction

   task automatic report_field(input string field_name, input logic [10:0] want,
                               input logic [10:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, field_name, want, got);
         fail_count++;
      end
   endtask

   // one process at the rising edge: check results, then log beats and writes
   always @(posedge clock) begin
      tcw_pkg::tcw_rsp_type owed;
      if (!reset) begin
         cycle_count++;
         // result beat, cannot be held off
         if (rsp_valid) begin
            if (results_due.size() == 0) begin
               $display("%0t ns: result with nothing pending, actual %h",
                        $time, rsp_payload);
               fail_count++;
            end else begin
               owed = results_due.pop_front();
               report_field("cursor_position", owed.cursor_position,
                            rsp_payload.cursor_position);
               report_field("cell_char", 11'(owed.cell_char),
                            11'(rsp_payload.cell_char));
               report_field("cell_foreground", 11'(owed.cell_foreground),
                            11'(rsp_payload.cell_foreground));
               report_field("cell_background", 11'(owed.cell_background),
                            11'(rsp_payload.cell_background));
               report_field("scrolled", 11'(owed.scrolled), 11'(rsp_payload.scrolled));
            end
         end
         // request beat accepted at this edge
         if (start && !busy) begin
            case (req_payload.action)
               tcw_pkg::ACT_PUT:   put_count++;
               tcw_pkg::ACT_CLEAR: clear_count++;
               tcw_pkg::ACT_READ:  read_count++;
               default:            other_count++;
            endcase
            owed = console_step(req_payload);
            if (owed.scrolled)
               scroll_count++;
            results_due.push_back(owed);
         end
         // register write, taken at once
         if (csr_we) begin
            case (csr_index)
               tcw_pkg::CSR_FOREGROUND: shadow_fg = csr_wdata;
               tcw_pkg::CSR_BACKGROUND: shadow_bg = csr_wdata;
               default: ;
            endcase
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // send one beat; start stays high afterward unless the next call idles
   task automatic send_beat(input tcw_pkg::tcw_req_type beat);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct && gap < MAX_GAP) begin
         start <= 1'b0;
         @(negedge clock);
         gap++;
      end
      start       <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [1:0] action, input logic [7:0] char_code,
                              input logic [10:0] cell_address);
      tcw_pkg::tcw_req_type beat;
      beat.action       = action;
      beat.char_code    = char_code;
      beat.cell_address = cell_address;
      send_beat(beat);
   endtask

   // drop start, let every owed result arrive, then a short pause
   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (results_due.size() != 0 || busy)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [tcw_pkg::CSR_IDX_W-1:0] index,
                            input logic [tcw_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // blank screen after reset, out-of-range reads and the unused action
   task automatic test_reset_contents();
      send_fields(tcw_pkg::ACT_READ, 8'($urandom), 11'd0);
      send_fields(tcw_pkg::ACT_READ, 8'($urandom), 11'(tcw_pkg::CELL_COUNT - 1));
      send_fields(tcw_pkg::ACT_READ, 8'($urandom), 11'(tcw_pkg::CELL_COUNT));
      send_fields(tcw_pkg::ACT_READ, 8'($urandom), 11'h7FF);
      send_fields(ACT_UNUSED, 8'hFF, 11'h7FF);
   endtask

   // byte decoding at the class boundaries, then read each cell back
   task automatic test_put_decoding();
      logic [7:0] probes [7];
      int i;
      probes = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF};
      for (i = 0; i < 7; i++)
         send_fields(tcw_pkg::ACT_PUT, probes[i], 11'h7FF);
      // one more printable cell, then read all eight back
      send_fields(tcw_pkg::ACT_PUT, 8'h41, 11'd0);
      for (i = 0; i < 8; i++)
         send_fields(tcw_pkg::ACT_READ, 8'h00, 11'(i));
      send_fields(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_NEWLINE, 11'd0);
      send_fields(tcw_pkg::ACT_READ, 8'($urandom), 11'(tcw_pkg::COLUMNS));
   endtask

   task automatic test_clear();
      send_fields(tcw_pkg::ACT_CLEAR, 8'($urandom), 11'($urandom));
      send_fields(tcw_pkg::ACT_READ, 8'($urandom), 11'd3);
   endtask

   // newlines down to the bottom row, then a full row wraps and scrolls,
   // then a newline scrolls again
   task automatic test_screen_end();
      int i;
      while (shadow_row != tcw_pkg::ROWS - 1)
         send_fields(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_NEWLINE, 11'($urandom));
      for (i = 0; i < tcw_pkg::COLUMNS; i++)
         send_fields(tcw_pkg::ACT_PUT, 8'($urandom_range(8'h20, 8'h7E)), 11'($urandom));
      send_fields(tcw_pkg::ACT_READ, 8'($urandom),
                  11'(tcw_pkg::MOVE_COUNT - tcw_pkg::COLUMNS));
      send_fields(tcw_pkg::ACT_READ, 8'($urandom), 11'(tcw_pkg::MOVE_COUNT));
      send_fields(tcw_pkg::ACT_PUT, tcw_pkg::CHAR_NEWLINE, 11'($urandom));
      send_fields(tcw_pkg::ACT_READ, 8'($urandom), 11'(tcw_pkg::MOVE_COUNT - 1));
   endtask

   // mostly text with newlines, reads near the cursor or anywhere, rare clears and unused actions
   task automatic test_random_phase(input int idle_pct, input logic [3:0] fg,
                                    input logic [3:0] bg, input int beats);
      tcw_pkg::tcw_req_type beat;
      int n;
      int pick;
      int cursor;
      wait_idle();
      write_csr(tcw_pkg::CSR_FOREGROUND, fg);
      write_csr(tcw_pkg::CSR_BACKGROUND, bg);
      sender_idle_pct = idle_pct;
      for (n = 0; n < beats; n++) begin
         pick = $urandom_range(99);
         beat.action       = tcw_pkg::ACT_PUT;
         beat.char_code    = 8'($urandom);
         beat.cell_address = 11'($urandom);
         if (pick < 60) begin
            beat.char_code = 8'($urandom_range(8'h20, 8'h7F));
         end else if (pick < 72) begin
            beat.char_code = tcw_pkg::CHAR_NEWLINE;
         end else if (pick < 78) begin
            // any byte, control and high codes included
         end else if (pick < 79) begin
            beat.action = tcw_pkg::ACT_CLEAR;
         end else if (pick < 97) begin
            beat.action = tcw_pkg::ACT_READ;
            cursor = shadow_row * tcw_pkg::COLUMNS + shadow_col;
            pick = $urandom_range(9);
            if (pick < 5)
               beat.cell_address = 11'(cursor - $urandom_range(0, (cursor < 160) ? cursor : 160));
            else if (pick < 9)
               beat.cell_address = 11'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
            else
               beat.cell_address = 11'($urandom_range(tcw_pkg::CELL_COUNT, 2047));
         end else begin
            beat.action = ACT_UNUSED;
         end
         send_beat(beat);
      end
   endtask

   initial begin
      int i;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      fail_count  = 0;
      cycle_count = 0;
      put_count   = 0;
      clear_count = 0;
      read_count  = 0;
      other_count = 0;
      scroll_count = 0;
      sender_idle_pct = 0;
      for (i = 0; i < tcw_pkg::CELL_COUNT; i++)
         shadow_screen[i] = tcw_pkg::BLANK_CELL;
      shadow_col = 0;
      shadow_row = 0;
      shadow_fg  = tcw_pkg::FOREGROUND_RESET;
      shadow_bg  = tcw_pkg::BACKGROUND_RESET;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      // the block clears its store after reset; send_beat waits on busy

      // directed checks run at the reset colors
      test_reset_contents();
      test_put_decoding();
      test_clear();
      test_screen_end();

      // random phases: color extremes, then random colors, changing idling
      test_random_phase(36, 4'h0, 4'hF, 125);
      test_random_phase(87, 4'hF, 4'h0, 125);
      test_random_phase(0, 4'($urandom), 4'($urandom), 125);

      wait_idle();
      repeat (10) @(negedge clock);
      $display("covered %0d puts, %0d reads, %0d clears, %0d unused-action beats",
               put_count, read_count, clear_count, other_count);
      $display("screen scrolled %0d times in %0d cycles", scroll_count, cycle_count);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== text_console_writer.f =====
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/text_console_writer.sv
test/tb_text_console_writer.sv
